@@ hw/rtl/bpfa_pkg.sv @@
package bpfa_pkg;

	// One bitmap memory word holds this many frame bits.
	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned BIT_AW    = 5;

	// Fixed field widths of the request and result ports.
	localparam int unsigned OP_W      = 2;
	localparam int unsigned BYTES_W   = 17;
	localparam int unsigned FRAME_W   = 15;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned PAGE_W    = 6;
	localparam int unsigned STATUS_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_ALLOC  = 2'd2,
		OP_FREE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_BAD_SIZE = 3'd1,
		ST_TOO_MANY = 3'd2,
		ST_NO_ROOM  = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE_CHK,
		S_PAGES,
		S_CHECK,
		S_SCAN
	} state_t;

endpackage

@@ hw/rtl/bitmap_page_frame_allocator.sv @@
// First-fit page frame allocator over a bitmap of frames (1 = used, 0 = free).
// Requests: a request (op and its fields) is taken at a rising edge with start
// high and busy low. Clear, append and requests with bad fields end at that edge;
// other frees and allocates keep busy high until their last result is produced.
// Results: each result is shown for one cycle with done high. The receiver
// cannot hold results off, so nothing here waits on it. free_frames carries
// the free count after the whole request; last marks the final result.
// Sequence: clear and append give their result in the cycle after the request
// and a new request can follow at once. Free reads the bitmap word, then
// releases the frame if it is used. Allocate first counts pages with a
// subtractor, one page per cycle, then checks the free count, then scans the
// bitmap one 32-bit word per cycle, while a word with a free frame holds the
// scan for each page it grants; a full scan of 32768 frames covers 1024 words.
// The single-port word read of the bitmap memory sets the scan rate.
// Reset: counts and the state machine clear at once; the bitmap memory is not
// cleared, since only frames that were appended are ever read.
module bitmap_page_frame_allocator #(
	parameter int unsigned MAX_FRAMES = 32768,
	parameter int unsigned PAGE_BYTES = 1024,
	parameter int unsigned MAX_PAGES  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic        bit_value,
	input  logic [16:0] request_bytes,
	input  logic [14:0] frame_index,
	output logic        done,
	output logic [2:0]  status,
	output logic [5:0]  page_number,
	output logic [14:0] frame_number,
	output logic [15:0] free_frames,
	output logic        last
);

	localparam int unsigned WORDS = (MAX_FRAMES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
	localparam int unsigned WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned PAGE_LIMIT = MAX_PAGES * PAGE_BYTES;
	localparam logic [16:0] PAGE_STEP = 17'(PAGE_BYTES);
	localparam logic [16:0] FRAME_CAP = 17'(MAX_FRAMES);
	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

	// Bitmap memory, one word per row.
	logic [31:0] mem [WORDS];
	logic [31:0] rd_data_q;
	logic rd_en;
	logic [WORD_AW-1:0] rd_addr;
	logic wr_en;
	logic [WORD_AW-1:0] wr_addr;
	logic [31:0] wr_data;
	logic [31:0] wr_mask;

	// Control and datapath registers.
	bpfa_pkg::state_t state_q, state_d;
	logic [15:0] loaded_q, loaded_d;
	logic [15:0] free_q, free_d;
	logic [WORD_AW-1:0] word_q, word_d;
	logic [4:0] bitsel_q, bitsel_d;
	logic [16:0] rem_q, rem_d;
	logic [6:0] pages_q, pages_d;
	logic [5:0] page_no_q, page_no_d;
	logic fresh_q, fresh_d;
	logic [31:0] work_q, work_d;

	// Result registers.
	logic done_q, done_d;
	bpfa_pkg::status_t status_q, status_d;
	logic [5:0] page_q, page_d;
	logic [14:0] frame_q, frame_d;
	logic last_q, last_d;

	// Scan helpers.
	logic [15:0] word_base;
	logic [31:0] valid_mask;
	logic [31:0] cur_word;
	logic [31:0] cur_marked;
	logic hit;
	logic [4:0] hit_pos;
	logic last_page;

	// Memory write with bit enables and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 32; i++) begin
				if (wr_mask[i]) begin
					mem[wr_addr][i] <= wr_data[i];
				end
			end
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Frames at or above the loaded count read as used during a scan.
	always_comb begin
		word_base = 16'({word_q, 5'b00000});
		for (int i = 0; i < 32; i++) begin
			valid_mask[i] = (loaded_q > word_base) && ((loaded_q - word_base) > 16'(i));
		end
		cur_word = fresh_q ? (rd_data_q | ~valid_mask) : work_q;
	end

	// Lowest free bit of the current word.
	always_comb begin
		hit = 1'b0;
		hit_pos = '0;
		for (int i = 31; i >= 0; i--) begin
			if (!cur_word[i]) begin
				hit = 1'b1;
				hit_pos = 5'(i);
			end
		end
		cur_marked = cur_word | (32'd1 << hit_pos);
		last_page = ((7'(page_no_q) + 7'd1) == pages_q);
	end

	// Sequencer: next state, register updates and memory controls.
	always_comb begin
		state_d = state_q;
		loaded_d = loaded_q;
		free_d = free_q;
		word_d = word_q;
		bitsel_d = bitsel_q;
		rem_d = rem_q;
		pages_d = pages_q;
		page_no_d = page_no_q;
		fresh_d = fresh_q;
		work_d = work_q;
		done_d = 1'b0;
		status_d = bpfa_pkg::ST_OK;
		page_d = '0;
		frame_d = '0;
		last_d = 1'b1;
		rd_en = 1'b0;
		rd_addr = word_q;
		wr_en = 1'b0;
		wr_addr = word_q;
		wr_data = '0;
		wr_mask = '0;

		unique case (state_q)
			bpfa_pkg::S_IDLE: begin
				if (start) begin
					unique case (bpfa_pkg::op_t'(op))
						bpfa_pkg::OP_CLEAR: begin
							loaded_d = '0;
							free_d = '0;
							done_d = 1'b1;
						end
						bpfa_pkg::OP_APPEND: begin
							if ({1'b0, loaded_q} < FRAME_CAP) begin
								wr_en = 1'b1;
								wr_addr = WORD_AW'(loaded_q >> 5);
								wr_mask = 32'd1 << loaded_q[4:0];
								wr_data = {32{bit_value}};
								loaded_d = loaded_q + 16'd1;
								if (!bit_value) begin
									free_d = free_q + 16'd1;
								end
							end
							done_d = 1'b1;
						end
						bpfa_pkg::OP_FREE: begin
							if ({1'b0, frame_index} >= loaded_q) begin
								done_d = 1'b1;
								status_d = bpfa_pkg::ST_RANGE;
							end else begin
								rd_en = 1'b1;
								rd_addr = WORD_AW'(frame_index >> 5);
								word_d = WORD_AW'(frame_index >> 5);
								bitsel_d = frame_index[4:0];
								state_d = bpfa_pkg::S_FREE_CHK;
							end
						end
						bpfa_pkg::OP_ALLOC: begin
							if (request_bytes == '0) begin
								done_d = 1'b1;
								status_d = bpfa_pkg::ST_BAD_SIZE;
							end else if (32'(request_bytes) > PAGE_LIMIT) begin
								done_d = 1'b1;
								status_d = bpfa_pkg::ST_TOO_MANY;
							end else begin
								rem_d = request_bytes;
								pages_d = '0;
								state_d = bpfa_pkg::S_PAGES;
							end
						end
						default: begin
							state_d = bpfa_pkg::S_IDLE;
						end
					endcase
				end
			end

			// Release the frame if it is used.
			bpfa_pkg::S_FREE_CHK: begin
				if (rd_data_q[bitsel_q]) begin
					wr_en = 1'b1;
					wr_addr = word_q;
					wr_mask = 32'd1 << bitsel_q;
					wr_data = '0;
					free_d = free_q + 16'd1;
				end
				done_d = 1'b1;
				state_d = bpfa_pkg::S_IDLE;
			end

			// Round up to pages, one subtraction per cycle.
			bpfa_pkg::S_PAGES: begin
				pages_d = pages_q + 7'd1;
				if (rem_q <= PAGE_STEP) begin
					state_d = bpfa_pkg::S_CHECK;
				end else begin
					rem_d = rem_q - PAGE_STEP;
				end
			end

			// Reject if too few frames are free, else start the scan at word zero.
			bpfa_pkg::S_CHECK: begin
				if (16'(pages_q) > free_q) begin
					done_d = 1'b1;
					status_d = bpfa_pkg::ST_NO_ROOM;
					state_d = bpfa_pkg::S_IDLE;
				end else begin
					free_d = free_q - 16'(pages_q);
					page_no_d = '0;
					word_d = '0;
					rd_en = 1'b1;
					rd_addr = '0;
					fresh_d = 1'b1;
					state_d = bpfa_pkg::S_SCAN;
				end
			end

			// Grant one frame per cycle, or move on to the next word.
			bpfa_pkg::S_SCAN: begin
				if (hit) begin
					done_d = 1'b1;
					page_d = page_no_q;
					frame_d = 15'({word_q, hit_pos});
					last_d = last_page;
					if (last_page) begin
						wr_en = 1'b1;
						wr_addr = word_q;
						wr_mask = '1;
						wr_data = cur_marked;
						state_d = bpfa_pkg::S_IDLE;
					end else begin
						work_d = cur_marked;
						fresh_d = 1'b0;
						page_no_d = page_no_q + 6'd1;
					end
				end else begin
					if (!fresh_q) begin
						wr_en = 1'b1;
						wr_addr = word_q;
						wr_mask = '1;
						wr_data = work_q;
					end
					if (word_q == LAST_WORD) begin
						// The free count guarantees a frame, so this is only a safety exit.
						done_d = 1'b1;
						status_d = bpfa_pkg::ST_NO_ROOM;
						state_d = bpfa_pkg::S_IDLE;
					end else begin
						word_d = word_q + 1'b1;
						rd_en = 1'b1;
						rd_addr = word_q + 1'b1;
						fresh_d = 1'b1;
					end
				end
			end

			default: begin
				state_d = bpfa_pkg::S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfa_pkg::S_IDLE;
			loaded_q <= '0;
			free_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			loaded_q <= loaded_d;
			free_q <= free_d;
			done_q <= done_d;
		end
	end

	// Datapath and result payload.
	always_ff @(posedge clk) begin
		word_q <= word_d;
		bitsel_q <= bitsel_d;
		rem_q <= rem_d;
		pages_q <= pages_d;
		page_no_q <= page_no_d;
		fresh_q <= fresh_d;
		work_q <= work_d;
		status_q <= status_d;
		page_q <= page_d;
		frame_q <= frame_d;
		last_q <= last_d;
	end

	assign busy = (state_q != bpfa_pkg::S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign page_number = page_q;
	assign frame_number = frame_q;
	assign free_frames = free_q;
	assign last = last_q;

endmodule

@@ hw/rtl/bpfa_checker.sv @@
module bpfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [5:0]  page_number,
	input logic [14:0] frame_number,
	input logic        last
);

	// A result that is not the last one leaves the request still in progress.
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy)
		else $error("non-final result while idle");

	// Only a successful allocation gives more than one result.
	a_multi_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> status == bpfa_pkg::ST_OK)
		else $error("error status on a non-final result");

	// Every error ends its request at once.
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != bpfa_pkg::ST_OK |-> last)
		else $error("error result without last");

	// Error results carry no page or frame.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != bpfa_pkg::ST_OK |-> page_number == 6'd0 && frame_number == 15'd0)
		else $error("error result with page or frame");

	// An accepted request either finishes at once or keeps the block busy.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted request dropped");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.page_number(page_number),
	.frame_number(frame_number),
	.last(last)
);
